[hdl/iwc_pkg.sv]
// Package with shared constants, state encoding and control structs for the centroid block.
package iwc_pkg;

  // Default sizing of the frame and the fixed-point result.
  localparam int DEF_MAX_WIDTH     = 4096;
  localparam int DEF_MAX_HEIGHT    = 4096;
  localparam int DEF_FRACTION_BITS = 8;

  // Fixed widths of the external fields.
  localparam int PIX_W      = 8;
  localparam int OUT_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int DIM_W      = 13;
  localparam int BG_W       = 8;

  // Signed weight width: intensity minus background, -255..255.
  localparam int WEIGHT_W = PIX_W + 1;

  // One saturation check step plus one step per result bit.
  localparam int DIV_STEPS = OUT_W + 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 13'd1280;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd1024;
  localparam logic [BG_W-1:0]  RST_BACKGROUND   = 8'd0;

  // Controller states.
  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_FLUSH,
    ST_LOAD,
    ST_DIV_X,
    ST_DIV_Y,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic pix_ready;
    logic load_x;
    logic load_y;
    logic step;
    logic take_x;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_end;
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

[hdl/iwc_if.sv]
// Stream and configuration interfaces of the centroid block.
interface iwc_pixel_if
  import iwc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] intensity;

  modport source (output valid, output intensity, input ready);
  modport sink   (input valid, input intensity, output ready);
endinterface

interface iwc_result_if
  import iwc_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] centroid_x;
  logic signed [OUT_W-1:0] centroid_y;
  logic                    empty_frame;

  modport source (output valid, output centroid_x, output centroid_y, output empty_frame,
                  input ready);
  modport sink   (input valid, input centroid_x, input centroid_y, input empty_frame,
                  output ready);
endinterface

interface iwc_cfg_if
  import iwc_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/iwc_div.sv]
// Shared restoring divider producing a rounded, saturated signed fixed-point quotient.
module iwc_div
  import iwc_pkg::*;
#(
  parameter int NUM_W         = 45,
  parameter int DEN_W         = 33,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic                    step,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [OUT_W-1:0] quot
);

  // The dividend is |num| * 2^(F+1) + |den|, the divisor 2*|den|: this rounds half away from zero.
  localparam int NW     = NUM_W + FRACTION_BITS + 2;
  localparam int DVW    = DEN_W + 1 + OUT_W;
  localparam int DW     = (NW > DVW) ? NW : DVW;
  localparam int CNT_W  = $clog2(DIV_STEPS + 1);

  logic [NUM_W-1:0] num_mag;
  logic [DEN_W-1:0] den_mag;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dv;
  logic [OUT_W-1:0] q;
  logic             sat;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic             ge;

  // Magnitudes of the operands.
  assign num_mag = num[NUM_W-1] ? NUM_W'(0) - NUM_W'(num) : NUM_W'(num);
  assign den_mag = den[DEN_W-1] ? DEN_W'(0) - DEN_W'(den) : DEN_W'(den);

  assign ge   = (rem >= dv);
  assign done = (cnt == CNT_W'(DIV_STEPS));

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= CNT_W'(DIV_STEPS);
    end else if (load) begin
      cnt <= '0;
    end else if (step && !done) begin
      cnt <= cnt + 1'b1;
    end
  end

  // One quotient bit per step; the first step only detects overflow of the result range.
  always_ff @(posedge clk) begin
    if (load) begin
      rem <= DW'({num_mag, {(FRACTION_BITS + 1){1'b0}}}) + DW'(den_mag);
      dv  <= DW'({den_mag, 1'b0}) << OUT_W;
      q   <= '0;
      sat <= 1'b0;
      neg <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (step && !done) begin
      dv <= dv >> 1;
      if (cnt == '0) begin
        sat <= ge;
      end else begin
        q <= {q[OUT_W-2:0], ge};
        if (ge) begin
          rem <= rem - dv;
        end
      end
    end
  end

  // Sign and saturation of the magnitude.
  always_comb begin
    if (sat || q[OUT_W-1]) begin
      quot = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else if (neg) begin
      quot = OUT_W'(0) - q;
    end else begin
      quot = q;
    end
  end

endmodule

[hdl/iwc_datapath.sv]
// Datapath: configuration registers, pixel position, weighted sums, divider and result register.
module iwc_datapath
  import iwc_pkg::*;
#(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              st,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    pix_valid,
  input  logic [PIX_W-1:0]        intensity,
  input  logic                    res_ready,
  output logic                    res_valid,
  output logic signed [OUT_W-1:0] centroid_x,
  output logic signed [OUT_W-1:0] centroid_y,
  output logic                    empty_frame
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int PW    = CW + RW;
  localparam int SW_W  = PW + WEIGHT_W;
  localparam int SXY_W = PW + ((CW > RW) ? CW : RW) + WEIGHT_W;
  localparam int PX_W  = CW + 1 + WEIGHT_W;
  localparam int PY_W  = RW + 1 + WEIGHT_W;

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [BG_W-1:0]  background_level;

  logic [CW-1:0] column_index;
  logic [RW-1:0] row_index;
  logic [CW:0]   width_eff;
  logic [RW:0]   height_eff;
  logic          col_last;
  logic          row_last;
  logic          pix_fire;

  logic signed [WEIGHT_W-1:0] weight;
  logic signed [PX_W-1:0]     col_ext;
  logic signed [PX_W-1:0]     wx_ext;
  logic signed [PY_W-1:0]     row_ext;
  logic signed [PY_W-1:0]     wy_ext;
  logic signed [PX_W-1:0]     prod_x;
  logic signed [PY_W-1:0]     prod_y;
  logic signed [WEIGHT_W-1:0] weight_q;
  logic                       prod_valid;

  logic signed [SXY_W-1:0] sum_x_weight;
  logic signed [SXY_W-1:0] sum_y_weight;
  logic signed [SW_W-1:0]  sum_weight;

  logic signed [SXY_W-1:0] div_num;
  logic signed [OUT_W-1:0] div_quot;
  logic                    div_done;
  logic signed [OUT_W-1:0] res_x;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= RST_FRAME_WIDTH;
      frame_height     <= RST_FRAME_HEIGHT;
      background_level <= RST_BACKGROUND;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width      <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height     <= cfg_data[DIM_W-1:0];
        REG_BACKGROUND:   background_level <= cfg_data[BG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero counts as one, large values clamp to the maximum.
  always_comb begin
    if (frame_width == '0) begin
      width_eff = (CW + 1)'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      width_eff = (CW + 1)'(MAX_WIDTH);
    end else begin
      width_eff = (CW + 1)'(frame_width);
    end
    if (frame_height == '0) begin
      height_eff = (RW + 1)'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      height_eff = (RW + 1)'(MAX_HEIGHT);
    end else begin
      height_eff = (RW + 1)'(frame_height);
    end
  end

  assign pix_fire = pix_valid && cmd.pix_ready;
  assign col_last = ({1'b0, column_index} + 1'b1) >= width_eff;
  assign row_last = ({1'b0, row_index} + 1'b1) >= height_eff;

  // Raster position tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
    end else if (pix_fire) begin
      if (col_last) begin
        column_index <= '0;
        row_index    <= row_last ? '0 : row_index + 1'b1;
      end else begin
        column_index <= column_index + 1'b1;
      end
    end
  end

  // Weight and operand extension for the products.
  assign weight  = signed'({1'b0, intensity}) - signed'({1'b0, background_level});
  assign col_ext = signed'({{(PX_W - CW){1'b0}}, column_index});
  assign wx_ext  = {{(PX_W - WEIGHT_W){weight[WEIGHT_W-1]}}, weight};
  assign row_ext = signed'({{(PY_W - RW){1'b0}}, row_index});
  assign wy_ext  = {{(PY_W - WEIGHT_W){weight[WEIGHT_W-1]}}, weight};

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= pix_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      prod_x   <= col_ext * wx_ext;
      prod_y   <= row_ext * wy_ext;
      weight_q <= weight;
    end
  end

  // Accumulation stage; the sums clear when the result leaves for the output register.
  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      sum_x_weight <= '0;
      sum_y_weight <= '0;
      sum_weight   <= '0;
    end else if (prod_valid) begin
      sum_x_weight <= sum_x_weight + {{(SXY_W - PX_W){prod_x[PX_W-1]}}, prod_x};
      sum_y_weight <= sum_y_weight + {{(SXY_W - PY_W){prod_y[PY_W-1]}}, prod_y};
      sum_weight   <= sum_weight + {{(SW_W - WEIGHT_W){weight_q[WEIGHT_W-1]}}, weight_q};
    end
  end

  // Shared divider, first for the column sum and then for the row sum.
  assign div_num = cmd.load_y ? sum_y_weight : sum_x_weight;

  iwc_div #(
    .NUM_W         (SXY_W),
    .DEN_W         (SW_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .load (cmd.load_x || cmd.load_y),
    .step (cmd.step),
    .num  (div_num),
    .den  (sum_weight),
    .done (div_done),
    .quot (div_quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_x) begin
      res_x <= div_quot;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      empty_frame <= (sum_weight == '0);
      centroid_x  <= (sum_weight == '0) ? '0 : res_x;
      centroid_y  <= (sum_weight == '0) ? '0 : div_quot;
    end
  end

  assign st.frame_end = pix_fire && col_last && row_last;
  assign st.div_done  = div_done;
  assign st.out_busy  = res_valid && !res_ready;

  // The product stage must be drained before the sums are read out.
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_x || cmd.load_out) |-> !prod_valid)
    else $error("sums read while a product is still pending");

  // An empty frame always reports a zero centroid.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && empty_frame) |-> (centroid_x == '0 && centroid_y == '0))
    else $error("empty frame with nonzero centroid");

endmodule

[hdl/iwc_ctrl.sv]
// Controller state machine sequencing accumulation, division and result hand-off.
module iwc_ctrl
  import iwc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_ACCUM: begin
        cmd.pix_ready = 1'b1;
        if (st.frame_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load_x = 1'b1;
        state_next = ST_DIV_X;
      end
      ST_DIV_X: begin
        if (st.div_done) begin
          cmd.take_x = 1'b1;
          cmd.load_y = 1'b1;
          state_next = ST_DIV_Y;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DIV_Y: begin
        if (st.div_done) begin
          state_next = ST_OUT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_OUT: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  // A frame can only end while pixels are being taken.
  a_frame_end_accum: assert property (@(posedge clk) disable iff (rst)
    st.frame_end |-> (state == ST_ACCUM))
    else $error("frame end outside accumulation");

  // The divider is never stepped past its last step.
  a_no_overstep: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !st.div_done)
    else $error("divider stepped after completion");

endmodule

[hdl/intensity_weighted_centroid.sv]
// After the last pixel of a frame is accepted, the product stage drains and the shared divider
// computes the column quotient and then the row quotient; the result goes into the output register.
// Throughput: one pixel per cycle within a frame; pixel ready is low from the end of a frame until
// its result is loaded; a pending earlier result does not stop intake but holds that load until taken.
// Reset (synchronous, active high) clears position, sums and control and restores the
// register defaults: width 1280, height 1024, background 0.
module intensity_weighted_centroid
  import iwc_pkg::*;
#(
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input logic         clk,
  input logic         rst,
  iwc_cfg_if.sink     cfg,
  iwc_pixel_if.sink   pixel,
  iwc_result_if.source centroid
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // Configuration writes are always taken.
  assign cfg.ready   = 1'b1;
  assign pixel.ready = cmd.pix_ready;

  iwc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  iwc_datapath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .pix_valid   (pixel.valid),
    .intensity   (pixel.intensity),
    .res_ready   (centroid.ready),
    .res_valid   (centroid.valid),
    .centroid_x  (centroid.centroid_x),
    .centroid_y  (centroid.centroid_y),
    .empty_frame (centroid.empty_frame)
  );

endmodule

[tb/intensity_weighted_centroid_tb.sv]
// Self-checking testbench for the intensity-weighted centroid block, with its own centroid predictor.
module intensity_weighted_centroid_tb;
  import iwc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles allowed for the pipeline and divider to go quiet after the last result.
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 540;

  // Line length at which a nearly cancelled weight sum drives the centroid into saturation.
  localparam int SAT_LEN = 40;

  localparam longint CENTROID_MAX = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint CENTROID_MIN = -(64'sd1 <<< (OUT_W - 1));

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic                    is_empty;
  } centroid_t;

  logic clk;
  logic rst;

  iwc_pixel_if  pix_if();
  iwc_result_if res_if();
  iwc_cfg_if    cfg_if();

  intensity_weighted_centroid u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_if),
    .pixel    (pix_if),
    .centroid (res_if)
  );

  // Predictor state: register copies, raster position and running sums.
  logic [DIM_W-1:0] cfg_width;
  logic [DIM_W-1:0] cfg_height;
  logic [BG_W-1:0]  cfg_bg;
  int unsigned      col_pos;
  int unsigned      row_pos;
  longint           sum_xw;
  longint           sum_yw;
  longint           sum_w;

  centroid_t pending_centroids[$];
  bit        frame_closed;
  int        pixels_sent;
  int        error_count;
  int        src_idle_pct;
  int        sink_stall_pct;
  int        quiet_cycles = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Zero sizes count as one; sizes above the maximum are clamped.
  function automatic int unsigned dim_limit(input logic [DIM_W-1:0] v, input int unsigned max_v);
    if (v == 0) return 1;
    return (v > max_v) ? max_v : v;
  endfunction

  // Rounded, saturated fixed-point quotient of two signed sums.
  function automatic logic [OUT_W-1:0] weighted_quotient(input longint num, input longint den);
    bit              flip;
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    longint unsigned r;
    longint unsigned frac;
    longint unsigned mag;
    longint          val;
    flip = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = n / d;
    r = n % d;
    if (q > (64'd1 << OUT_W)) q = 64'd1 << OUT_W;
    // Round to nearest, ties away from zero, on the magnitude.
    frac = ((r << (DEF_FRACTION_BITS + 1)) + d) / (d << 1);
    mag = (q << DEF_FRACTION_BITS) + frac;
    if (flip) val = (mag > (64'd1 << (OUT_W - 1))) ? CENTROID_MIN : -longint'(mag);
    else val = (mag > CENTROID_MAX) ? CENTROID_MAX : longint'(mag);
    return val[OUT_W-1:0];
  endfunction

  // Accumulates one pixel; returns 1 with the centroid when it closes the frame.
  function automatic bit accumulate_pixel(input logic [PIX_W-1:0] value, output centroid_t res);
    int unsigned w_eff;
    int unsigned h_eff;
    longint      wt;
    w_eff = dim_limit(cfg_width, DEF_MAX_WIDTH);
    h_eff = dim_limit(cfg_height, DEF_MAX_HEIGHT);
    wt = longint'(value) - longint'(cfg_bg);
    res.x = '0;
    res.y = '0;
    res.is_empty = 1'b0;
    sum_xw += longint'(col_pos) * wt;
    sum_yw += longint'(row_pos) * wt;
    sum_w += wt;
    if (col_pos + 1 < w_eff) begin
      col_pos++;
      return 1'b0;
    end
    col_pos = 0;
    if (row_pos + 1 < h_eff) begin
      row_pos++;
      return 1'b0;
    end
    row_pos = 0;
    if (sum_w == 0) begin
      res.is_empty = 1'b1;
    end else begin
      res.x = weighted_quotient(sum_xw, sum_w);
      res.y = weighted_quotient(sum_yw, sum_w);
    end
    sum_xw = 0;
    sum_yw = 0;
    sum_w = 0;
    return 1'b1;
  endfunction

  // Sends one pixel transaction, with random gaps before it.
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    centroid_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.intensity <= value;
    do @(posedge clk); while (!pix_if.ready);
    frame_closed = accumulate_pixel(value, res);
    if (frame_closed) pending_centroids.push_back(res);
    pixels_sent++;
  endtask

  task automatic send_list(input logic [PIX_W-1:0] vals[$]);
    foreach (vals[i]) send_pixel(vals[i]);
  endtask

  // One line of n pixels: a first value, then a low half and a high half.
  task automatic send_split_line(input int n, input logic [PIX_W-1:0] first,
                                 input logic [PIX_W-1:0] low, input logic [PIX_W-1:0] high);
    for (int i = 0; i < n; i++) begin
      send_pixel((i == 0) ? first : ((i < n / 2) ? low : high));
    end
  endtask

  // Holds off the pixel stream until every expected centroid has come out.
  task automatic wait_for_results();
    pix_if.valid <= 1'b0;
    while (pending_centroids.size() != 0) @(posedge clk);
  endtask

  // Register write while the block is quiet.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH: cfg_width = value;
      REG_FRAME_HEIGHT: cfg_height = value;
      REG_BACKGROUND: cfg_bg = value[BG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] bg);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_BACKGROUND, bg);
  endtask

  // Small frames: single bright corners, a negative weight, empty frames.
  task automatic test_basic_frames();
    set_frame(2, 2, 0);
    send_list('{8'd255, 8'd0, 8'd0, 8'd0});
    send_list('{8'd0, 8'd0, 8'd0, 8'd255});
    write_reg(REG_BACKGROUND, 255);
    send_list('{8'd255, 8'd255, 8'd255, 8'd0});
    write_reg(REG_UNUSED, 13'h1FFF);
    // Weights cancel to zero although the pixels are not at background.
    set_frame(2, 1, 128);
    send_list('{8'd100, 8'd156});
    send_list('{8'd128, 8'd128});
  endtask

  // Quotients that land exactly halfway between two fraction steps.
  task automatic test_rounding();
    set_frame(4, 1, 0);
    send_list('{8'd255, 8'd254, 8'd2, 8'd1});
    set_frame(6, 1, 128);
    send_list('{8'd0, 8'd0, 8'd0, 8'd0, 8'd127, 8'd129});
  endtask

  // Zero and oversized geometry, and saturation both ways on both axes.
  task automatic test_size_limits();
    set_frame(0, 0, 0);
    send_list('{8'd200});
    // An oversized width or height holds the frame open until it is cut back.
    set_frame(13'h1FFF, 0, 0);
    send_list('{8'd9, 8'd8, 8'd7, 8'd6, 8'd5});
    write_reg(REG_FRAME_WIDTH, 3);
    send_list('{8'd4});
    set_frame(2, 13'h1FFF, 0);
    send_list('{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6});
    write_reg(REG_FRAME_HEIGHT, 1);
    send_list('{8'd7, 8'd8});
    // The weights nearly cancel while the first moment stays large.
    set_frame(CFG_DATA_W'(SAT_LEN), 1, 128);
    send_split_line(SAT_LEN, 8'd0, 8'd1, 8'd255);
    send_split_line(SAT_LEN, 8'd2, 8'd1, 8'd255);
    set_frame(1, CFG_DATA_W'(SAT_LEN), 128);
    send_split_line(SAT_LEN, 8'd0, 8'd1, 8'd255);
    send_split_line(SAT_LEN, 8'd2, 8'd1, 8'd255);
  endtask

  // Geometry and background changed partway through a frame.
  task automatic test_midframe_changes();
    set_frame(4, 2, 0);
    send_list('{8'd10, 8'd20, 8'd30});
    write_reg(REG_FRAME_WIDTH, 2);
    send_list('{8'd40});
    write_reg(REG_BACKGROUND, 16);
    send_list('{8'd50, 8'd60});
    set_frame(1, 4, 0);
    send_list('{8'd1, 8'd2, 8'd3});
    write_reg(REG_FRAME_HEIGHT, 2);
    send_list('{8'd4});
  endtask

  // Mostly small sizes, now and then a larger one or a zero.
  function automatic logic [CFG_DATA_W-1:0] random_dim();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick == 0) return '0;
    if (pick == 1) return CFG_DATA_W'($urandom_range(9, 40));
    return CFG_DATA_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_background();
    case ($urandom_range(3))
      0: return '0;
      1: return CFG_DATA_W'(16);
      2: return CFG_DATA_W'(128);
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Pixel content styles: uniform, at background, extremes, near background.
  function automatic logic [PIX_W-1:0] random_pixel(input int style);
    int delta;
    case (style)
      0: return PIX_W'($urandom_range(255));
      1: return cfg_bg;
      2: return $urandom_range(1) ? 8'd255 : 8'd0;
      default: begin
        delta = int'(cfg_bg) + $urandom_range(6) - 3;
        if (delta < 0) delta = 0;
        if (delta > 255) delta = 255;
        return PIX_W'(delta);
      end
    endcase
  endfunction

  // Whole frames of random content under random geometry and background.
  task automatic test_random_traffic(input int item_goal, input int send_idle, input int recv_stall);
    int start;
    int style;
    int idx;
    src_idle_pct = send_idle;
    sink_stall_pct = recv_stall;
    start = pixels_sent;
    while (pixels_sent - start < item_goal) begin
      if ($urandom_range(2) == 0) begin
        write_reg(REG_FRAME_WIDTH, random_dim());
        write_reg(REG_FRAME_HEIGHT, random_dim());
      end
      if ($urandom_range(3) == 0) write_reg(REG_BACKGROUND, random_background());
      style = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
      idx = 0;
      do begin
        // A rare register change in the middle of the frame.
        if (idx > 0 && $urandom_range(39) == 0) begin
          case ($urandom_range(2))
            0: write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(1, 8)));
            1: write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(1, 8)));
            default: write_reg(REG_BACKGROUND, random_background());
          endcase
        end
        send_pixel(random_pixel(style));
        idx++;
      end while (!frame_closed);
      if ($urandom_range(7) == 0) wait_for_results();
    end
  endtask

  // Result side: random stalls and a field-by-field check of each transaction.
  always @(posedge clk) begin
    centroid_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pending_centroids.size() == 0) begin
          report_mismatch($sformatf("unexpected result x=%0d y=%0d empty=%0b",
                                    res_if.centroid_x, res_if.centroid_y, res_if.empty_frame));
        end else begin
          want = pending_centroids.pop_front();
          if (res_if.centroid_x !== want.x)
            report_mismatch($sformatf("centroid_x expected %0d, got %0d",
                                      want.x, res_if.centroid_x));
          if (res_if.centroid_y !== want.y)
            report_mismatch($sformatf("centroid_y expected %0d, got %0d",
                                      want.y, res_if.centroid_y));
          if (res_if.empty_frame !== want.is_empty)
            report_mismatch($sformatf("empty_frame expected %0b, got %0b",
                                      want.is_empty, res_if.empty_frame));
        end
      end
      res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT at %0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    rst <= 1'b1;
    pix_if.valid <= 1'b0;
    pix_if.intensity <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    cfg_width = RST_FRAME_WIDTH;
    cfg_height = RST_FRAME_HEIGHT;
    cfg_bg = RST_BACKGROUND;
    col_pos = 0;
    row_pos = 0;
    sum_xw = 0;
    sum_yw = 0;
    sum_w = 0;
    frame_closed = 1'b0;
    pixels_sent = 0;
    error_count = 0;
    src_idle_pct = 22;
    sink_stall_pct = 54;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_frames();
    test_rounding();
    test_size_limits();
    test_midframe_changes();
    test_random_traffic(RANDOM_ITEMS, 22, 54);
    test_random_traffic(RANDOM_ITEMS, 54, 22);
    test_random_traffic(RANDOM_ITEMS, 0, 0);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[intensity_weighted_centroid.f]
hdl/iwc_pkg.sv
hdl/iwc_if.sv
hdl/iwc_div.sv
hdl/iwc_datapath.sv
hdl/iwc_ctrl.sv
hdl/intensity_weighted_centroid.sv
tb/intensity_weighted_centroid_tb.sv
